FILE: rtl/core/hmt_pkg.sv
// Shared types and constants of the wire hit merge table.
`default_nettype none

package hmt_pkg;

  localparam int TIME_W     = 16;
  localparam int QIN_W      = 16;
  localparam int CHARGE_W   = 24;
  localparam int RADIUS_W   = 13;
  localparam int TRACK_W    = 16;
  localparam int PART_W     = 8;
  localparam int LIMIT_W    = 6;
  localparam int APB_AW     = 4;
  localparam int APB_DW     = 32;
  localparam int REG_IDX_W  = 2;

  // Command codes of an input word
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Register indexes (byte address = 4 * index)
  localparam logic [REG_IDX_W-1:0] REG_RESOLUTION = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT      = 2'd2;

  localparam logic [TIME_W-1:0]  RESOLUTION_RST = 16'd400;
  localparam logic [TIME_W-1:0]  WINDOW_RST     = 16'd16000;
  localparam logic [LIMIT_W-1:0] LIMIT_RST      = 6'd32;

  typedef struct packed {
    logic [TIME_W-1:0]   hit_time;
    logic [CHARGE_W-1:0] charge;
    logic [RADIUS_W-1:0] radius;
    logic [TRACK_W-1:0]  track;
    logic [PART_W-1:0]   particle;
  } entry_t;

  typedef struct packed {
    logic lt;    // op_a < op_b
    logic near;  // |op_a - op_b| < window
  } cmp_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_SCAN,
    ST_ADD_MERGE,
    ST_FL_SCAN,
    ST_FL_WAIT
  } state_e;

endpackage

`default_nettype wire

FILE: rtl/core/hmt_item_if.sv
// Input channel: one cluster add or flush command per word.
`default_nettype none

interface hmt_item_if;
  import hmt_pkg::*;

  logic                valid;
  logic                ready;
  logic                command;
  logic [TIME_W-1:0]   hit_time;
  logic [QIN_W-1:0]    charge;
  logic [RADIUS_W-1:0] drift_radius;
  logic [TRACK_W-1:0]  track_id;
  logic [PART_W-1:0]   particle_type;

  modport source (
    output valid, command, hit_time, charge, drift_radius, track_id, particle_type,
    input  ready
  );

  modport sink (
    input  valid, command, hit_time, charge, drift_radius, track_id, particle_type,
    output ready
  );

endinterface

`default_nettype wire

FILE: rtl/core/hmt_result_if.sv
// Output channel: one merged hit per word during a flush.
`default_nettype none

interface hmt_result_if;
  import hmt_pkg::*;

  logic                valid;
  logic                ready;
  logic [TIME_W-1:0]   out_time;
  logic [CHARGE_W-1:0] out_charge;
  logic [RADIUS_W-1:0] out_radius;
  logic [TRACK_W-1:0]  out_track;
  logic [PART_W-1:0]   out_particle;
  logic                overflow_seen;
  logic                last;

  modport source (
    output valid, out_time, out_charge, out_radius, out_track, out_particle,
           overflow_seen, last,
    input  ready
  );

  modport sink (
    input  valid, out_time, out_charge, out_radius, out_track, out_particle,
           overflow_seen, last,
    output ready
  );

endinterface

`default_nettype wire

FILE: rtl/core/hit_merge_table.sv
// Top level of the wire hit merge table: sequencer, registers, APB port.
// Add word: the stored hits are scanned in order and the first one within the resolution
//   takes a merge (one table read per cycle into the shared comparator); a word out of
//   window is dropped. Flush word: one selection pass per emitted hit plus the output
//   handshake. Not ready while busy.
// Reset: registers return to 400 / 16000 / 32, the table is empty, no clearing pass.
`default_nettype none

module hit_merge_table #(
  parameter int TABLE_DEPTH = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  hmt_item_if.sink                          item_i,
  hmt_result_if.source                      result_o,
  // APB register port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [hmt_pkg::APB_AW-1:0]   paddr,
  input  wire logic [hmt_pkg::APB_DW-1:0]   pwdata,
  output logic      [hmt_pkg::APB_DW-1:0]   prdata,
  output logic                              pready
);
  import hmt_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  // Configuration
  logic [TIME_W-1:0]  res_q, win_q;
  logic [LIMIT_W-1:0] lim_q;
  logic [REG_IDX_W-1:0] reg_idx;
  logic               apb_wr;

  // Sequencer and table bookkeeping
  state_e          state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic            drop_q, drop_d;
  logic [CW-1:0]   addr_q, addr_d;     // next table entry to read
  logic            pend_q, pend_d;     // read data of pidx_q is waiting
  logic [IW-1:0]   pidx_q, pidx_d;
  logic            found_q, found_d;   // flush pass has a best candidate
  logic [CW-1:0]   cand_q, cand_d;     // candidates seen in this pass
  logic [IW-1:0]   best_idx_q, best_idx_d;
  logic [TABLE_DEPTH-1:0] done_q, done_d;  // already emitted in this flush
  logic            ov_valid_q, ov_valid_d;

  // Payload registers
  entry_t          cl_q, cl_d;         // cluster being added
  entry_t          best_q, best_d;
  entry_t          out_q, out_d;
  logic            out_ovf_q, out_ovf_d;
  logic            out_last_q, out_last_d;

  // Memory and comparator hookup
  logic            mem_we, mem_re;
  logic [IW-1:0]   mem_waddr;
  entry_t          mem_wdata;
  entry_t          rdata;
  logic [TIME_W-1:0] cmp_a, cmp_b;
  cmp_res_t        cmp;

  logic            item_fire, res_fire;
  logic            issue, pass_end, cand_ok, fits, late;
  logic [6:0]      lim_w;
  logic [CW-1:0]   lim_eff;
  logic [CHARGE_W:0] qsum;

  assign item_fire = item_i.valid & item_i.ready;
  assign res_fire  = result_o.valid & result_o.ready;

  // Limit is the smaller of the register and the table depth
  assign lim_w   = (7'(lim_q) > 7'(TABLE_DEPTH)) ? 7'(TABLE_DEPTH) : 7'(lim_q);
  assign lim_eff = CW'(lim_w);

  assign issue    = (addr_q < count_q);
  assign pass_end = !issue && !pend_q;
  assign cand_ok  = !done_q[pidx_q] && (rdata.charge != '0);
  assign fits     = (count_q < lim_eff);
  assign late     = (item_i.hit_time > win_q);
  assign qsum     = {1'b0, rdata.charge} + (CHARGE_W + 1)'(cl_q.charge);

  // ---------------------------------------------------------------------
  // APB: writes on the access phase, reads are combinational
  // ---------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign apb_wr  = psel & penable & pwrite & pready;

  always_comb begin
    unique case (reg_idx)
      REG_RESOLUTION: prdata = APB_DW'(res_q);
      REG_WINDOW:     prdata = APB_DW'(win_q);
      REG_LIMIT:      prdata = APB_DW'(lim_q);
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Shared comparator operand select
  //   add scan : stored time vs cluster time (window test)
  //   merge    : cluster time < stored time picks the earlier cluster
  //   flush    : stored time < best time (strict, so ties keep stored order)
  // ---------------------------------------------------------------------
  always_comb begin
    cmp_a = (state_q == ST_ADD_MERGE) ? cl_q.hit_time : rdata.hit_time;
    if (state_q == ST_FL_SCAN) begin
      cmp_b = best_q.hit_time;
    end else if (state_q == ST_ADD_MERGE) begin
      cmp_b = rdata.hit_time;
    end else begin
      cmp_b = cl_q.hit_time;
    end
  end

  hmt_cmp u_cmp (
    .op_a_i   (cmp_a),
    .op_b_i   (cmp_b),
    .window_i (res_q),
    .res_o    (cmp)
  );

  hmt_mem #(
    .DEPTH (TABLE_DEPTH),
    .IW    (IW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (addr_q[IW-1:0]),
    .rdata_o (rdata)
  );

  // ---------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (item_fire) begin
          if (item_i.command == CMD_FLUSH) begin
            state_d = ST_FL_SCAN;
          end else if (!late) begin
            state_d = ST_ADD_SCAN;
          end
        end
      end
      ST_ADD_SCAN: begin
        if (pend_q && cmp.near) begin
          state_d = ST_ADD_MERGE;
        end else if (!issue) begin
          state_d = ST_IDLE;
        end
      end
      ST_ADD_MERGE: state_d = ST_IDLE;
      ST_FL_SCAN: begin
        if (pass_end) begin
          state_d = found_q ? ST_FL_WAIT : ST_IDLE;
        end
      end
      ST_FL_WAIT: begin
        if (res_fire) begin
          state_d = out_last_q ? ST_IDLE : ST_FL_SCAN;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Datapath and memory control
  // ---------------------------------------------------------------------
  always_comb begin
    count_d    = count_q;
    drop_d     = drop_q;
    addr_d     = addr_q;
    pend_d     = pend_q;
    pidx_d     = pidx_q;
    found_d    = found_q;
    cand_d     = cand_q;
    best_idx_d = best_idx_q;
    done_d     = done_q;
    ov_valid_d = ov_valid_q;
    cl_d       = cl_q;
    best_d     = best_q;
    out_d      = out_q;
    out_ovf_d  = out_ovf_q;
    out_last_d = out_last_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = pidx_q;
    mem_wdata  = rdata;

    unique case (state_q)
      ST_IDLE: begin
        if (item_fire) begin
          cl_d.hit_time = item_i.hit_time;
          cl_d.charge   = CHARGE_W'(item_i.charge);
          cl_d.radius   = item_i.drift_radius;
          cl_d.track    = item_i.track_id;
          cl_d.particle = item_i.particle_type;
          addr_d  = '0;
          pend_d  = 1'b0;
          found_d = 1'b0;
          cand_d  = '0;
          done_d  = '0;
        end
      end

      ST_ADD_SCAN: begin
        if (pend_q && cmp.near) begin
          // hold the matching word in the read register for the merge
        end else if (issue) begin
          mem_re = 1'b1;
          addr_d = addr_q + CW'(1);
          pend_d = 1'b1;
          pidx_d = addr_q[IW-1:0];
        end else if (fits) begin
          mem_we    = 1'b1;
          mem_waddr = count_q[IW-1:0];
          mem_wdata = cl_q;
          count_d   = count_q + CW'(1);
        end else begin
          drop_d = 1'b1;
        end
      end

      ST_ADD_MERGE: begin
        mem_we    = 1'b1;
        mem_waddr = pidx_q;
        mem_wdata = cmp.lt ? cl_q : rdata;
        mem_wdata.charge = qsum[CHARGE_W] ? '1 : qsum[CHARGE_W-1:0];
      end

      ST_FL_SCAN: begin
        pend_d = issue;
        if (issue) begin
          mem_re = 1'b1;
          addr_d = addr_q + CW'(1);
          pidx_d = addr_q[IW-1:0];
        end
        if (pend_q && cand_ok) begin
          cand_d = cand_q + CW'(1);
          if (!found_q || cmp.lt) begin
            best_d     = rdata;
            best_idx_d = pidx_q;
            found_d    = 1'b1;
          end
        end
        if (pass_end) begin
          if (found_q) begin
            out_d      = best_q;
            out_ovf_d  = drop_q;
            out_last_d = (cand_q == CW'(1));
            ov_valid_d = 1'b1;
            done_d[best_idx_q] = 1'b1;
          end else begin
            // nothing with charge: clear only
            count_d = '0;
            drop_d  = 1'b0;
          end
        end
      end

      ST_FL_WAIT: begin
        if (res_fire) begin
          ov_valid_d = 1'b0;
          if (out_last_q) begin
            count_d = '0;
            drop_d  = 1'b0;
          end else begin
            addr_d  = '0;
            pend_d  = 1'b0;
            found_d = 1'b0;
            cand_d  = '0;
          end
        end
      end

      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q      <= RESOLUTION_RST;
      win_q      <= WINDOW_RST;
      lim_q      <= LIMIT_RST;
      state_q    <= ST_IDLE;
      count_q    <= '0;
      drop_q     <= 1'b0;
      addr_q     <= '0;
      pend_q     <= 1'b0;
      pidx_q     <= '0;
      found_q    <= 1'b0;
      cand_q     <= '0;
      best_idx_q <= '0;
      done_q     <= '0;
      ov_valid_q <= 1'b0;
    end else begin
      if (apb_wr) begin
        unique case (reg_idx)
          REG_RESOLUTION: res_q <= pwdata[TIME_W-1:0];
          REG_WINDOW:     win_q <= pwdata[TIME_W-1:0];
          REG_LIMIT:      lim_q <= pwdata[LIMIT_W-1:0];
          default: begin
          end
        endcase
      end
      state_q    <= state_d;
      count_q    <= count_d;
      drop_q     <= drop_d;
      addr_q     <= addr_d;
      pend_q     <= pend_d;
      pidx_q     <= pidx_d;
      found_q    <= found_d;
      cand_q     <= cand_d;
      best_idx_q <= best_idx_d;
      done_q     <= done_d;
      ov_valid_q <= ov_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cl_q       <= cl_d;
    best_q     <= best_d;
    out_q      <= out_d;
    out_ovf_q  <= out_ovf_d;
    out_last_q <= out_last_d;
  end

  // ---------------------------------------------------------------------
  // Channel drive
  // ---------------------------------------------------------------------
  assign item_i.ready           = (state_q == ST_IDLE);
  assign result_o.valid         = ov_valid_q;
  assign result_o.out_time      = out_q.hit_time;
  assign result_o.out_charge    = out_q.charge;
  assign result_o.out_radius    = out_q.radius;
  assign result_o.out_track     = out_q.track;
  assign result_o.out_particle  = out_q.particle;
  assign result_o.overflow_seen = out_ovf_q;
  assign result_o.last          = out_last_q;

endmodule

`default_nettype wire

FILE: rtl/core/hmt_mem.sv
// Hit table storage: one write port, one read port with registered data.
`default_nettype none

module hmt_mem #(
  parameter int DEPTH = 32,
  parameter int IW    = 5
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [IW-1:0]    waddr_i,
  input  wire hmt_pkg::entry_t  wdata_i,
  input  wire logic             re_i,
  input  wire logic [IW-1:0]    raddr_i,
  output hmt_pkg::entry_t       rdata_o
);
  import hmt_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/core/hmt_cmp.sv
// Shared time comparator: order and two-hit window test.
`default_nettype none

module hmt_cmp (
  input  wire logic [hmt_pkg::TIME_W-1:0] op_a_i,
  input  wire logic [hmt_pkg::TIME_W-1:0] op_b_i,
  input  wire logic [hmt_pkg::TIME_W-1:0] window_i,
  output hmt_pkg::cmp_res_t               res_o
);
  import hmt_pkg::*;

  logic [TIME_W:0]   diff;
  logic [TIME_W-1:0] mag;

  always_comb begin
    diff = {1'b0, op_a_i} - {1'b0, op_b_i};
    // borrow out means a < b
    mag  = diff[TIME_W] ? (op_b_i - op_a_i) : diff[TIME_W-1:0];
    res_o.lt   = diff[TIME_W];
    res_o.near = (mag < window_i);
  end

endmodule

`default_nettype wire

FILE: dv/hit_merge_table_test.sv
// Self-checking testbench of the wire hit merge table: directed and random words, APB setup.
`default_nettype none

module hit_merge_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hmt_pkg::*;

  localparam int DEPTH       = 32;
  localparam int SETTLE      = 80;   // margin for a trailing add scan to finish
  localparam int LONG_HOLD   = 400;  // receiver hold-off that backs the table up
  localparam int RANDOM_GOAL = 150;  // directed plus random words; saturation adds ~259 more
  localparam int SAT_ADDS    = 258;  // 258 * 65535 is past the 24-bit charge ceiling

  // One input word as the sender sees it.
  typedef struct packed {
    logic                cmd;
    logic [TIME_W-1:0]   hit_time;
    logic [QIN_W-1:0]    charge;
    logic [RADIUS_W-1:0] radius;
    logic [TRACK_W-1:0]  track;
    logic [PART_W-1:0]   particle;
  } cluster_t;

  // One emitted hit.
  typedef struct packed {
    logic [TIME_W-1:0]   hit_time;
    logic [CHARGE_W-1:0] charge;
    logic [RADIUS_W-1:0] radius;
    logic [TRACK_W-1:0]  track;
    logic [PART_W-1:0]   particle;
    logic                overflow;
    logic                last;
  } hit_t;

  // Shadow of the wire's hit table plus the queue of hits that a flush owes us.
  class wire_hit_book;
    logic [TIME_W-1:0]   tbl_time     [DEPTH];
    logic [CHARGE_W-1:0] tbl_charge   [DEPTH];
    logic [RADIUS_W-1:0] tbl_radius   [DEPTH];
    logic [TRACK_W-1:0]  tbl_track    [DEPTH];
    logic [PART_W-1:0]   tbl_particle [DEPTH];
    int unsigned         stored;
    bit                  dropped;
    logic [TIME_W-1:0]   resolution;
    logic [TIME_W-1:0]   window;
    logic [LIMIT_W-1:0]  limit;
    hit_t                due_hits[$];
    int unsigned         faults;

    function new();
      resolution = RESOLUTION_RST;
      window     = WINDOW_RST;
      limit      = LIMIT_RST;
      stored     = 0;
      dropped    = 1'b0;
      faults     = 0;
    endfunction

    function void flag(string what);
      faults++;
      if (faults <= 10) $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [APB_DW-1:0] value);
      case (idx)
        REG_RESOLUTION: resolution = value[TIME_W-1:0];
        REG_WINDOW:     window     = value[TIME_W-1:0];
        REG_LIMIT:      limit      = value[LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return due_hits.size();
    endfunction

    // Merge into the first hit in stored order within the resolution, else append.
    function void take_cluster(cluster_t c);
      int unsigned cap;
      int unsigned slot;
      int          span;
      logic [CHARGE_W:0] sum;
      cap  = (limit < DEPTH) ? limit : DEPTH;
      slot = stored;
      if (c.hit_time > window) return;
      for (int i = 0; i < stored; i++) begin
        span = int'(tbl_time[i]) - int'(c.hit_time);
        if (span < 0) span = -span;
        if (slot == stored && span < int'(resolution)) slot = i;
      end
      if (slot < stored) begin
        sum = {1'b0, tbl_charge[slot]} + (CHARGE_W + 1)'(c.charge);
        tbl_charge[slot] = sum[CHARGE_W] ? {CHARGE_W{1'b1}} : sum[CHARGE_W-1:0];
        // strictly earlier cluster takes over; equal time keeps the stored hit
        if (tbl_time[slot] > c.hit_time) begin
          tbl_time[slot]     = c.hit_time;
          tbl_radius[slot]   = c.radius;
          tbl_track[slot]    = c.track;
          tbl_particle[slot] = c.particle;
        end
      end else if (stored < cap) begin
        tbl_time[stored]     = c.hit_time;
        tbl_charge[stored]   = CHARGE_W'(c.charge);
        tbl_radius[stored]   = c.radius;
        tbl_track[stored]    = c.track;
        tbl_particle[stored] = c.particle;
        stored++;
      end else begin
        dropped = 1'b1;
      end
    endfunction

    // Stable time sort of the charged hits, queued in emit order, then clear.
    function void drain_table();
      int   order[DEPTH];
      int   j;
      int   k;
      hit_t h;
      k = 0;
      for (int i = 0; i < stored; i++) begin
        if (tbl_charge[i] != '0) begin
          j = k;
          while (j > 0 && tbl_time[order[j-1]] > tbl_time[i]) begin
            order[j] = order[j-1];
            j--;
          end
          order[j] = i;
          k++;
        end
      end
      for (int n = 0; n < k; n++) begin
        h.hit_time = tbl_time[order[n]];
        h.charge   = tbl_charge[order[n]];
        h.radius   = tbl_radius[order[n]];
        h.track    = tbl_track[order[n]];
        h.particle = tbl_particle[order[n]];
        h.overflow = dropped;
        h.last     = (n == k - 1);
        due_hits.push_back(h);
      end
      stored  = 0;
      dropped = 1'b0;
    endfunction

    function void note_word(cluster_t c);
      if (c.cmd == CMD_FLUSH) drain_table();
      else take_cluster(c);
    endfunction

    function string show(hit_t h);
      return $sformatf("t=%0d q=%0d r=%0d trk=%0d pt=%0d ovf=%b last=%b",
                       h.hit_time, h.charge, h.radius, h.track, h.particle,
                       h.overflow, h.last);
    endfunction

    function void check_hit(hit_t got);
      hit_t  want;
      string bad;
      bad = "";
      if (due_hits.size() == 0) begin
        flag({"hit with none due: ", show(got)});
        return;
      end
      want = due_hits.pop_front();
      if (got.hit_time !== want.hit_time) bad = {bad, " time"};
      if (got.charge   !== want.charge)   bad = {bad, " charge"};
      if (got.radius   !== want.radius)   bad = {bad, " radius"};
      if (got.track    !== want.track)    bad = {bad, " track"};
      if (got.particle !== want.particle) bad = {bad, " particle"};
      if (got.overflow !== want.overflow) bad = {bad, " overflow"};
      if (got.last     !== want.last)     bad = {bad, " last"};
      if (bad != "") flag({"hit field", bad, ": expected ", show(want), ", got ", show(got)});
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  wire  [APB_DW-1:0]   prdata;
  wire                 pready;

  hmt_item_if   cluster_ch ();
  hmt_result_if hit_ch ();

  wire_hit_book book = new();

  int unsigned words_sent = 0;
  bit          steady = 1'b0;       // phase without idling on either side
  bit          hold_off_req = 1'b0; // asks the receiver for one long hold-off

  hit_merge_table #(
    .TABLE_DEPTH (DEPTH)
  ) DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (cluster_ch),
    .result_o (hit_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Hard stop: well above the slowest legal run.
  initial begin
    #4ms;
    $display("TEST FAILED");
    $finish;
  end

  // Mostly no gap, sometimes a short one, now and then a long one.
  function automatic int idle_cycles();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  // Offer one word at a falling edge, hold it until taken at a rising edge.
  // valid is left high on return; the next word or wait_idle takes it over.
  task automatic send_word(input cluster_t c);
    int gap;
    gap = idle_cycles();
    @(negedge clk_i);
    if (gap > 0) begin
      cluster_ch.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cluster_ch.valid         = 1'b1;
    cluster_ch.command       = c.cmd;
    cluster_ch.hit_time      = c.hit_time;
    cluster_ch.charge        = c.charge;
    cluster_ch.drift_radius  = c.radius;
    cluster_ch.track_id      = c.track;
    cluster_ch.particle_type = c.particle;
    do @(posedge clk_i); while (!cluster_ch.ready);
    book.note_word(c);
    words_sent++;
  endtask

  task automatic add_word(input int t, input int q, input int r, input int trk, input int pt);
    send_word('{cmd: CMD_ADD, hit_time: TIME_W'(t), charge: QIN_W'(q),
                radius: RADIUS_W'(r), track: TRACK_W'(trk), particle: PART_W'(pt)});
  endtask

  // Payload of a flush is don't-care for the block, so it carries noise.
  task automatic flush_word();
    send_word('{cmd: CMD_FLUSH, hit_time: TIME_W'($urandom), charge: QIN_W'($urandom),
                radius: RADIUS_W'($urandom), track: TRACK_W'($urandom),
                particle: PART_W'($urandom)});
  endtask

  // Drop valid, let every owed hit arrive, then let a trailing add scan finish.
  task automatic wait_idle();
    @(negedge clk_i);
    cluster_ch.valid = 1'b0;
    while (book.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic logic [APB_DW-1:0] reg_bits(input logic [REG_IDX_W-1:0] idx);
    return (idx == REG_LIMIT) ? APB_DW'((1 << LIMIT_W) - 1) : APB_DW'((1 << TIME_W) - 1);
  endfunction

  task automatic reg_check(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] want);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = {idx, 2'b00};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if ((prdata & reg_bits(idx)) !== (want & reg_bits(idx)))
      book.flag($sformatf("register %0d read: expected %0d, got %0d",
                          idx, want & reg_bits(idx), prdata & reg_bits(idx)));
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Setup then access; the register takes the value at the access edge.
  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    book.set_reg(idx, value);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    reg_check(idx, value);
  endtask

  task automatic set_config(input int res, input int win, input int lim);
    wait_idle();
    reg_write(REG_RESOLUTION, APB_DW'(res));
    reg_write(REG_WINDOW, APB_DW'(win));
    reg_write(REG_LIMIT, APB_DW'(lim));
  endtask

  // Result side: random ready at falling edges, long hold-off on request.
  initial begin
    int hold_left;
    int roll;
    hit_ch.ready = 1'b0;
    hold_left    = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hit_ch.ready = 1'b0;
        hold_left--;
      end else if (steady) begin
        hit_ch.ready = 1'b1;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 65) begin
          hit_ch.ready = 1'b1;
        end else begin
          hit_ch.ready = 1'b0;
          hold_left    = (roll < 95) ? $urandom_range(0, 3) : $urandom_range(15, 60);
        end
      end
    end
  end

  // Every taken hit is compared against the oldest one owed.
  always @(posedge clk_i) begin
    if (hit_ch.valid && hit_ch.ready)
      book.check_hit('{hit_time: hit_ch.out_time, charge: hit_ch.out_charge,
                       radius: hit_ch.out_radius, track: hit_ch.out_track,
                       particle: hit_ch.out_particle, overflow: hit_ch.overflow_seen,
                       last: hit_ch.last});
  end

  initial begin
    int res, win, lim;
    int bursts, adds, nb, spread, top, t, q, roll;
    int bases[6];
    bit squeeze;
    int phase;

    rst_ni                   = 1'b0;
    psel                     = 1'b0;
    penable                  = 1'b0;
    pwrite                   = 1'b0;
    paddr                    = '0;
    pwdata                   = '0;
    cluster_ch.valid         = 1'b0;
    cluster_ch.command       = CMD_ADD;
    cluster_ch.hit_time      = '0;
    cluster_ch.charge        = '0;
    cluster_ch.drift_radius  = '0;
    cluster_ch.track_id      = '0;
    cluster_ch.particle_type = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    reg_check(REG_RESOLUTION, APB_DW'(RESOLUTION_RST));
    reg_check(REG_WINDOW, APB_DW'(WINDOW_RST));
    reg_check(REG_LIMIT, APB_DW'(LIMIT_RST));

    // ---- directed, reset settings: 400 resolution, 16000 window, limit 32 ----
    flush_word();                           // empty table: nothing comes out
    add_word(1000, 10, 1, 1, 1);
    add_word(1399, 5, 2, 2, 2);             // 399 apart: merges, stored hit stays
    add_word(1400, 0, 3, 3, 3);             // exactly 400 apart: new zero-charge hit
    add_word(600, 7, 8191, 65535, 255);     // field maxima, own hit
    add_word(1000, 3, 4, 4, 4);             // equal time merge keeps stored fields
    add_word(16000, 65535, 5, 5, 5);        // right on the window edge: kept
    add_word(16001, 1, 6, 6, 6);            // one past the window: dropped
    add_word(65535, 9, 7, 7, 7);            // time maximum: dropped
    add_word(0, 65535, 0, 0, 0);            // time zero, charge maximum
    add_word(800, 2, 9, 9, 9);              // earlier cluster takes over the first hit
    add_word(1400, 4, 10, 10, 10);          // zero-charge hit becomes visible
    flush_word();

    // no merging, tiny table: equal times leave in stored order, overflow shows
    set_config(0, 65535, 2);
    add_word(5, 1, 11, 11, 11);
    add_word(5, 2, 12, 12, 12);
    add_word(3, 0, 13, 13, 13);             // table full: dropped, flag set
    flush_word();
    flush_word();                           // empty, and the flag is cleared

    // zero limit and zero window
    set_config(1, 0, 0);
    add_word(0, 5, 14, 14, 14);             // in window, but nothing may be stored
    add_word(1, 6, 15, 15, 15);             // past the window
    flush_word();

    // ---- random phases: bursts of adds around a few times, then a flush ----
    phase = 0;
    while (words_sent < RANDOM_GOAL) begin
      squeeze = (phase == 0 || phase == 4);
      case ($urandom_range(0, 4))
        0:       res = 0;
        1:       res = 65535;
        2:       res = $urandom_range(1, 1000);
        default: res = $urandom_range(0, 65535);
      endcase
      case ($urandom_range(0, 4))
        0:       win = 0;
        1, 2:    win = 65535;
        3:       win = 16000;
        default: win = $urandom_range(0, 65535);
      endcase
      case ($urandom_range(0, 5))
        0:       lim = 0;
        1:       lim = 1;
        2:       lim = 63;
        3:       lim = $urandom_range(33, 62);
        4:       lim = 32;
        default: lim = $urandom_range(2, 31);
      endcase
      // the hold-off phases need a table that fills
      if (squeeze) begin
        win = 65535;
        lim = 32;
      end
      set_config(res, win, lim);
      steady = ($urandom_range(0, 3) == 0) && !squeeze;

      spread = (res == 0) ? 4 : ((res > 2000) ? 4000 : 2 * res + 2);
      top    = win + win / 8 + 1;
      if (top > 65535) top = 65535;
      bursts = $urandom_range(2, 3);
      for (int b = 0; b < bursts; b++) begin
        nb   = $urandom_range(1, 6);
        for (int i = 0; i < nb; i++) bases[i] = $urandom_range(0, top);
        adds = squeeze ? $urandom_range(8, 40) : $urandom_range(0, 40);
        for (int a = 0; a < adds; a++) begin
          if ($urandom_range(0, 3) == 0) t = $urandom_range(0, 65535);
          else t = bases[$urandom_range(0, nb - 1)] + $urandom_range(0, spread);
          if (t > 65535) t = 65535;
          roll = $urandom_range(0, 9);
          q = (roll == 0) ? 0 : ((roll == 1) ? 65535 : $urandom_range(0, 65535));
          add_word(t, q, $urandom_range(0, 8191), $urandom_range(0, 65535),
                   $urandom_range(0, 255));
        end
        // long receiver stall while the next burst keeps pushing
        if (squeeze && b == 0) hold_off_req = 1'b1;
        flush_word();
        if ($urandom_range(0, 9) == 0) flush_word();
      end
      phase++;
    end

    // ---- saturation: everything merges into one hit until the sum pins ----
    set_config(65535, 65535, $urandom_range(1, 32));
    steady = 1'b1;
    for (int a = 0; a < SAT_ADDS; a++)
      add_word($urandom_range(0, 60000), 65535, $urandom_range(0, 8191),
               $urandom_range(0, 65535), $urandom_range(0, 255));
    steady = 1'b0;
    flush_word();

    wait_idle();
    if (book.faults == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
